[src/rgbhsl_pkg.sv]
package rgbhsl_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned DVD_W  = 17;   // largest dividend is 510*255 + 255
  localparam int unsigned DVS_W  = 9;    // largest divisor is 510
  localparam int unsigned NSTEP  = CH_W; // one quotient bit per divider stage
  localparam int unsigned SH_W   = $clog2(NSTEP);
  localparam int unsigned OQ_DEPTH = 2;
  localparam int unsigned WQ_DEPTH = 2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] hue_out;
    logic [CH_W-1:0] sat_out;
    logic [CH_W-1:0] light_out;
  } hsl_t;

  // classified item: two divisions still to do, lightness already known
  typedef struct packed {
    logic [DVD_W-1:0] sat_dvd;
    logic [DVS_W-1:0] sat_dvs;
    logic [DVD_W-1:0] hue_dvd;
    logic [DVS_W-1:0] hue_dvs;
    logic [CH_W-1:0]  light;
  } work_t;

  typedef struct packed {
    logic [DVD_W-1:0] sat_rem;
    logic [DVS_W-1:0] sat_dvs;
    logic [CH_W-1:0]  sat_q;
    logic [DVD_W-1:0] hue_rem;
    logic [DVS_W-1:0] hue_dvs;
    logic [CH_W-1:0]  hue_q;
    logic [CH_W-1:0]  light;
  } stage_t;

  typedef struct packed {
    logic [DVD_W-1:0] rem;
    logic             qbit;
  } step_t;

  // one restoring division step for quotient bit sh
  function automatic step_t div_step(input logic [DVD_W-1:0] rem,
                                     input logic [DVS_W-1:0] dvs,
                                     input logic [SH_W-1:0]  sh);
    logic [DVD_W-1:0] sub;
    step_t            res;
    sub = DVD_W'(dvs) << sh;
    if (rem >= sub) begin
      res.rem  = rem - sub;
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

[src/rgbhsl_front.sv]
module rgbhsl_front
  import rgbhsl_pkg::*;
(
  input  pixel_t pix,
  output work_t  work
);

  logic [CH_W-1:0]      mx;
  logic [CH_W-1:0]      mn;
  logic [CH_W:0]        sum;
  logic [CH_W:0]        sum_p1;
  logic [CH_W-1:0]      delta;
  logic [CH_W-1:0]      den;
  logic                 grey;
  logic                 red_max;
  logic                 green_max;
  logic [CH_W+1:0]      kd;
  logic signed [11:0]   dif;
  logic signed [11:0]   t;
  logic signed [19:0]   num_s;
  logic signed [19:0]   num_w;
  logic [17:0]          d510;

  always_comb begin
    mx = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx)  mx = pix.blue;
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn)  mn = pix.blue;
  end

  assign sum    = {1'b0, mx} + {1'b0, mn};
  assign sum_p1 = sum + 9'd1;
  assign delta  = mx - mn;
  assign grey   = (delta == '0);
  assign den    = sum[CH_W] ? CH_W'(9'd511 - sum) : sum[CH_W-1:0];
  assign d510   = 18'(delta) * 18'd510;

  // sector: ties go to red, then green
  assign red_max   = (pix.red == mx);
  assign green_max = !red_max && (pix.green == mx);

  always_comb begin
    if (red_max) begin
      kd  = '0;
      dif = $signed({4'b0, pix.green}) - $signed({4'b0, pix.blue});
    end else if (green_max) begin
      kd  = {1'b0, delta, 1'b0};
      dif = $signed({4'b0, pix.blue}) - $signed({4'b0, pix.red});
    end else begin
      kd  = {delta, 2'b0};
      dif = $signed({4'b0, pix.red}) - $signed({4'b0, pix.green});
    end
  end

  assign t     = $signed({2'b0, kd}) + dif;
  assign num_s = 20'(t) * $signed(20'd85);
  // negative hue wraps by a full turn of 255
  assign num_w = (num_s < 0) ? num_s + $signed({2'b0, d510}) : num_s;

  always_comb begin
    work.light = sum_p1[CH_W:1];
    if (grey) begin
      work.sat_dvd = '0;
      work.sat_dvs = DVS_W'(1);
      work.hue_dvd = '0;
      work.hue_dvs = DVS_W'(1);
    end else begin
      work.sat_dvd = DVD_W'(d510) + DVD_W'(den);
      work.sat_dvs = {den, 1'b0};
      work.hue_dvd = DVD_W'(num_w) + DVD_W'(delta);
      work.hue_dvs = {delta, 1'b0};
    end
  end

endmodule

[src/rgbhsl_work_q.sv]
module rgbhsl_work_q
  import rgbhsl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t wr_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output work_t rd_data
);

  localparam int unsigned PTR_W = $clog2(WQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(WQ_DEPTH + 1);

  work_t            mem_r [WQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(WQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

endmodule

[src/rgbhsl_back.sv]
module rgbhsl_back
  import rgbhsl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  work_valid,
  input  work_t work,
  output logic  work_pop,
  output logic  empty,
  input  logic  pop,
  output hsl_t  res
);

  localparam int unsigned PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OQ_DEPTH + 1);

  stage_t           st_r   [NSTEP];
  stage_t           st_nxt [NSTEP];
  stage_t           src    [NSTEP];
  logic [NSTEP-1:0] vld_r;
  logic             adv;
  logic             oq_full;
  logic             oq_push;
  logic             oq_pop;
  hsl_t             oq_r [OQ_DEPTH];
  logic [PTR_W-1:0] owp_r, owp_nxt;
  logic [PTR_W-1:0] orp_r, orp_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  hsl_t             fin;

  // the whole divider pipe holds while its last stage cannot drain
  assign adv      = !(vld_r[NSTEP-1] && oq_full);
  assign work_pop = adv && work_valid;

  always_comb begin
    src[0].sat_rem = work.sat_dvd;
    src[0].sat_dvs = work.sat_dvs;
    src[0].sat_q   = '0;
    src[0].hue_rem = work.hue_dvd;
    src[0].hue_dvs = work.hue_dvs;
    src[0].hue_q   = '0;
    src[0].light   = work.light;
  end

  genvar i;
  generate
    for (i = 1; i < NSTEP; i++) begin : g_src
      assign src[i] = st_r[i-1];
    end
    for (i = 0; i < NSTEP; i++) begin : g_step
      step_t sres;
      step_t hres;
      always_comb begin
        sres = div_step(src[i].sat_rem, src[i].sat_dvs, SH_W'(NSTEP - 1 - i));
        hres = div_step(src[i].hue_rem, src[i].hue_dvs, SH_W'(NSTEP - 1 - i));
        st_nxt[i]                   = src[i];
        st_nxt[i].sat_rem           = sres.rem;
        st_nxt[i].sat_q[NSTEP-1-i]  = sres.qbit;
        st_nxt[i].hue_rem           = hres.rem;
        st_nxt[i].hue_q[NSTEP-1-i]  = hres.qbit;
      end
      always_ff @(posedge clk) begin
        if (adv) st_r[i] <= st_nxt[i];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTEP-2:0], work_valid};
    end
  end

  // output queue
  assign fin.hue_out   = st_r[NSTEP-1].hue_q;
  assign fin.sat_out   = st_r[NSTEP-1].sat_q;
  assign fin.light_out = st_r[NSTEP-1].light;

  assign oq_full = (ocnt_r == CNT_W'(OQ_DEPTH));
  assign empty   = (ocnt_r == '0);
  assign oq_push = adv && vld_r[NSTEP-1];
  assign oq_pop  = pop && !empty;
  assign res     = oq_r[orp_r];

  always_comb begin
    owp_nxt  = oq_push ? owp_r + 1'b1 : owp_r;
    orp_nxt  = oq_pop ? orp_r + 1'b1 : orp_r;
    ocnt_nxt = ocnt_r;
    if (oq_push && !oq_pop) ocnt_nxt = ocnt_r + 1'b1;
    if (oq_pop && !oq_push) ocnt_nxt = ocnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[owp_r] <= fin;
  end

endmodule

[src/rgb_to_hsl_8bit_core.sv]
// channel   ports                      direction  payload
// input     push, full, in_pixel       in         red, green, blue (8 bits each)
// result    pop, empty, out_pixel      out        hue_out, sat_out, light_out (8 bits each)
//
// one item per clock sustained while the result queue is popped; an item taken by push reaches
// out_pixel through the work queue write, eight divider stages (one quotient bit per stage for
// saturation and hue side by side) and the result queue write, the work queue adding no wait
// while the pipe moves
// reset clears queue pointers, counts and pipe valid bits; payload is not reset
// when the result queue is full and the last pipe stage holds an item the pipe freezes
// as a whole, the work queue then fills and raises full
module rgb_to_hsl_8bit_core
  import rgbhsl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  output logic   full,
  input  pixel_t in_pixel,
  output logic   empty,
  input  logic   pop,
  output hsl_t   out_pixel
);

  work_t work_in;
  work_t work_head;
  logic  wq_empty;
  logic  wq_pop;

  rgbhsl_front u_front (
    .pix  (in_pixel),
    .work (work_in)
  );

  rgbhsl_work_q u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (work_in),
    .full    (full),
    .pop     (wq_pop),
    .empty   (wq_empty),
    .rd_data (work_head)
  );

  rgbhsl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work_valid (!wq_empty),
    .work       (work_head),
    .work_pop   (wq_pop),
    .empty      (empty),
    .pop        (pop),
    .res        (out_pixel)
  );

endmodule

[dv/rgb_to_hsl_8bit_core_test.sv]
`timescale 1ns / 1ps

module rgb_to_hsl_8bit_core_test;
  import rgbhsl_pkg::*;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   push = 1'b0;
  logic   full;
  pixel_t in_pixel = '0;
  logic   empty;
  logic   pop = 1'b0;
  hsl_t   out_pixel;

  hsl_t expected_hsl[$];
  int   mismatches = 0;
  int   tx_idle_pct = 27;
  int   rx_idle_pct = 27;
  int   rx_hold_left = 0;

  rgb_to_hsl_8bit_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_pixel(in_pixel),
    .empty(empty),
    .pop(pop),
    .out_pixel(out_pixel)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // exact rational hsl, every output rounded half up
  function automatic hsl_t compute_hsl(input pixel_t p);
    int r, g, b, mx, mn, sum, delta, k, d, num, den;
    hsl_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = mx + mn;
    delta = mx - mn;
    res.light_out = 8'((sum + 1) >> 1);
    res.sat_out = '0;
    res.hue_out = '0;
    if (delta != 0) begin
      den = (sum < 256) ? sum : (511 - sum);
      res.sat_out = 8'((2 * 255 * delta + den) / (2 * den));
      // ties go to red first, then green
      if (r == mx) begin
        k = 0;
        d = g - b;
      end else if (g == mx) begin
        k = 2;
        d = b - r;
      end else begin
        k = 4;
        d = r - g;
      end
      num = 85 * (k * delta + d);
      den = 2 * delta;
      if (num < 0) num += 255 * den;
      res.hue_out = 8'((2 * num + den) / (2 * den));
    end
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = pixel_t'(24'($urandom));
    case ($urandom_range(9))
      0: begin
        p.green = p.red;
        p.blue = p.red;
      end
      1: p.green = p.red;
      2: p.blue = p.green;
      3: p.blue = p.red;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    push <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (full);
    expected_hsl.push_back(compute_hsl(p));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (expected_hsl.size() != 0);
  endtask

  // receiver: random pop, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_hsl.size() == 0) begin
        $error("unexpected item: hue_out %0d sat_out %0d light_out %0d",
               out_pixel.hue_out, out_pixel.sat_out, out_pixel.light_out);
        mismatches++;
      end else begin
        hsl_t want;
        want = expected_hsl.pop_front();
        if (out_pixel.hue_out !== want.hue_out) begin
          $error("hue_out: expected %0d, got %0d", want.hue_out, out_pixel.hue_out);
          mismatches++;
        end
        if (out_pixel.sat_out !== want.sat_out) begin
          $error("sat_out: expected %0d, got %0d", want.sat_out, out_pixel.sat_out);
          mismatches++;
        end
        if (out_pixel.light_out !== want.light_out) begin
          $error("light_out: expected %0d, got %0d", want.light_out, out_pixel.light_out);
          mismatches++;
        end
      end
    end
  end

  task automatic test_corner_pixels();
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd128, 8'd128, 8'd128});
    send_pixel({8'd255, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd255});
    // tied maxima
    send_pixel({8'd255, 8'd255, 8'd0});
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd255});
    send_pixel({8'd90, 8'd90, 8'd10});
    // hue next to the wrap point, rounding up to a full turn or to zero
    send_pixel({8'd255, 8'd0, 8'd1});
    send_pixel({8'd200, 8'd3, 8'd4});
    send_pixel({8'd255, 8'd1, 8'd0});
    send_pixel({8'd1, 8'd0, 8'd0});
    // saturation divisor either side of the midpoint
    send_pixel({8'd255, 8'd1, 8'd1});
    send_pixel({8'd128, 8'd127, 8'd127});
    send_pixel({8'd254, 8'd255, 8'd255});
    send_pixel({8'd170, 8'd85, 8'd85});
    send_pixel({8'd1, 8'd2, 8'd3});
    send_pixel({8'd85, 8'd170, 8'd255});
    send_pixel({8'd0, 8'd1, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd1});
    send_pixel({8'd127, 8'd128, 8'd129});
    send_pixel({8'd200, 8'd100, 8'd150});
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic test_no_idling();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (150) send_pixel(random_pixel());
    tx_idle_pct = 27;
    rx_idle_pct = 27;
  endtask

  task automatic test_output_stall();
    int saved_tx;
    saved_tx = tx_idle_pct;
    tx_idle_pct = 0;
    rx_hold_left = 200;
    // far more items than the pipe and both queues hold
    repeat (40) send_pixel(random_pixel());
    tx_idle_pct = saved_tx;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_pixels();
    test_random_stream(400);
    test_output_stall();
    test_no_idling();
    wait_drained();
    test_random_stream(230);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
